// ----- rtl/sil_pkg.sv -----
package sil_pkg;

  // Field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CountW   = 6;
  localparam int unsigned StatusW  = 2;

  // Default store depth
  localparam int unsigned DefaultCapacity = 32;

  // Command codes, also used as the result kind
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CmdW-1:0] CMD_SIZE   = 2'd2;
  localparam logic [CmdW-1:0] CMD_DUMP   = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INS_RD  = 6'b000010,
    ST_INS_CMP = 6'b000100,
    ST_DMP_RD  = 6'b001000,
    ST_DMP_OUT = 6'b010000,
    ST_RESP    = 6'b100000
  } state_e;

endpackage

// ----- rtl/sil_req_if.sv -----
interface sil_req_if
  import sil_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          cmd;
  logic signed [DataW-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/sil_rsp_if.sv -----
interface sil_rsp_if
  import sil_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          kind;
  logic signed [DataW-1:0]  element;
  logic [CountW-1:0]        count;
  logic [StatusW-1:0]       status;
  logic                     last;

  modport source (output valid, output kind, output element, output count,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input element, input count,
                  input status, input last, output ready);
endinterface

// ----- rtl/sil_ram.sv -----
module sil_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sorted_insertion_list_core.sv -----
// Sorted store of up to CAPACITY signed 32-bit values, kept in ascending order in a
// RAM with one write port and one read port. One request is taken at a time;
// req_i.ready is high only while the sequencer is idle. Insert walks down from the top
// entry, shifting each entry that is greater than or equal to the new value one place
// up, so a new value lands below the equal values already stored. Each insert step
// reads the entry below, then compares it and writes either that entry one place up
// or the new value; it stops on a smaller entry or when the value lands in entry 0.
// A full store drops the value with status full. Clear and size go straight to their
// result. Dump reads each stored value (RAM read then output load) and emits one result
// per value in ascending order, last set on the final one; an empty store gives one
// result with status empty. Each entry visited needs a registered read through the one
// RAM read port before the single comparator or the output can use it; a result that
// cannot enter the result register holds the sequencer until it is free. The result
// register lets a finished result wait for rsp_o.ready while the block returns to idle
// and takes the next request. The store needs no clearing after reset; only the count is reset.
module sorted_insertion_list_core
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sil_req_if.sink   req_i,
  sil_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CmdW-1:0]        cmd_q, cmd_d;
  logic [DataW-1:0]       val_q, val_d;
  logic [StatusW-1:0]     status_q, status_d;

  // Result register
  logic                   rsp_valid_q, rsp_valid_d;
  logic [CmdW-1:0]        rsp_kind_q, rsp_kind_d;
  logic [DataW-1:0]       rsp_elem_q, rsp_elem_d;
  logic [CountW-1:0]      rsp_count_q, rsp_count_d;
  logic [StatusW-1:0]     rsp_status_q, rsp_status_d;
  logic                   rsp_last_q, rsp_last_d;

  // RAM port
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [DataW-1:0]       ram_wdata, ram_rdata;

  logic                   out_free;
  logic [CW+CountW-1:0]   count_ext;

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign count_ext = {{CountW{1'b0}}, count_q};

  sil_ram #(
    .Width (DataW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    cmd_d        = cmd_q;
    val_d        = val_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = '0;
    ram_wdata    = '0;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_kind_d   = rsp_kind_q;
    rsp_elem_d   = rsp_elem_q;
    rsp_count_d  = rsp_count_q;
    rsp_status_d = rsp_status_q;
    rsp_last_d   = rsp_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = req_i.cmd;
          val_d    = req_i.value;
          status_d = STATUS_OK;
          unique case (req_i.cmd)
            CMD_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                status_d = STATUS_FULL;
                state_d  = ST_RESP;
              end else begin
                pos_d   = count_q;
                state_d = ST_INS_RD;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              state_d = ST_RESP;
            end
            CMD_SIZE: begin
              state_d = ST_RESP;
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                pos_d   = '0;
                state_d = ST_DMP_RD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Bottom reached: the new value goes to entry 0; else read the entry below
      ST_INS_RD: begin
        if (pos_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pos_q - CW'(1));
          state_d   = ST_INS_CMP;
        end
      end

      // Smaller entry below: place here; else shift it up one slot
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        if ($signed(ram_rdata) < $signed(val_q)) begin
          ram_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = ST_RESP;
        end else begin
          ram_wdata = ram_rdata;
          pos_d     = pos_q - CW'(1);
          state_d   = ST_INS_RD;
        end
      end

      ST_DMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(pos_q);
        state_d   = ST_DMP_OUT;
      end

      ST_DMP_OUT: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_kind_d   = CMD_DUMP;
          rsp_elem_d   = ram_rdata;
          rsp_count_d  = count_ext[CountW-1:0];
          rsp_status_d = STATUS_OK;
          rsp_last_d   = (pos_q + CW'(1) == count_q);
          if (pos_q + CW'(1) == count_q) begin
            state_d = ST_IDLE;
          end else begin
            pos_d   = pos_q + CW'(1);
            state_d = ST_DMP_RD;
          end
        end
      end

      // Single result of insert, clear, size or empty dump
      ST_RESP: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_kind_d   = cmd_q;
          rsp_elem_d   = '0;
          rsp_count_d  = count_ext[CountW-1:0];
          rsp_status_d = status_q;
          rsp_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    status_q     <= status_d;
    rsp_kind_q   <= rsp_kind_d;
    rsp_elem_q   <= rsp_elem_d;
    rsp_count_q  <= rsp_count_d;
    rsp_status_q <= rsp_status_d;
    rsp_last_q   <= rsp_last_d;
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.kind    = rsp_kind_q;
  assign rsp_o.element = rsp_elem_q;
  assign rsp_o.count   = rsp_count_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.last    = rsp_last_q;

endmodule

// ----- rtl/sil_checker.sv -----
module sil_checker
  import sil_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [CmdW-1:0]    rsp_kind_i,
  input logic [DataW-1:0]   rsp_element_i,
  input logic [CountW-1:0]  rsp_count_i,
  input logic [StatusW-1:0] rsp_status_i,
  input logic               rsp_last_i
);

  logic [CountW:0] count_w;
  assign count_w = {1'b0, rsp_count_i};

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_element_i)
      && $stable(rsp_last_i) && $stable(rsp_kind_i))
    else $error("stalled result changed");

  // One request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // Count never above the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> count_w <= (CountW+1)'(CAPACITY))
    else $error("count above capacity");

  // Full status only on a final insert result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_FULL |-> rsp_kind_i == CMD_INSERT && rsp_last_i)
    else $error("bad full result");

  // Non-dump commands give a single zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i != CMD_DUMP |-> rsp_last_i && rsp_element_i == '0
      && rsp_status_i != STATUS_EMPTY)
    else $error("bad single result");

endmodule

bind sorted_insertion_list_core sil_checker #(
  .CAPACITY (CAPACITY)
) u_sil_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_kind_i    (rsp_o.kind),
  .rsp_element_i (rsp_o.element),
  .rsp_count_i   (rsp_o.count),
  .rsp_status_i  (rsp_o.status),
  .rsp_last_i    (rsp_o.last)
);
